// ===== hdl/adaptive_gate_frequency_meter_unit_assert.svh =====
// Assertion macros for the adaptive gate frequency meter.
`ifndef ADAPTIVE_GATE_FREQUENCY_METER_UNIT_ASSERT_SVH
`define ADAPTIVE_GATE_FREQUENCY_METER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off while arst_n is low
`define AGFM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("agfm assertion failed");
// next-cycle implication
`define AGFM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("agfm assertion failed");
`else
`define AGFM_ASSERT_NOW(lbl, ante, cons)
`define AGFM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/agfm_pkg.sv =====
// Shared types and constants of the adaptive gate frequency meter.
package agfm_pkg;

	localparam int FREQ_W    = 40;            // frequency_q8 width
	localparam int WIN_W     = 9;             // window length, 1..256
	localparam int MUL_W     = 16;            // serial multiplier operand width
	localparam int MUL_CNT_W = 5;             // counts MUL_W steps
	localparam int ADD_W     = 24;            // wraps*65536 + residual
	localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

	typedef enum logic [1:0] {
		REG_NORMAL_PERIOD = 2'd0,
		REG_TUNING_PERIOD = 2'd1,
		REG_SCALE_Q8      = 2'd2,
		REG_TOLERANCE_Q16 = 2'd3
	} cfg_reg_t;

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ===== hdl/agfm_sermul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
module agfm_sermul import agfm_pkg::*; #(
	parameter int AW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [AW-1:0]       a,
	input  logic [MUL_W-1:0]    b,
	output unit_stat_t          stat,
	output logic [AW+MUL_W-1:0] product
);

	localparam int PW = AW + MUL_W;

	logic [AW-1:0]        a_q;
	logic [MUL_W-1:0]     b_q;
	logic [PW-1:0]        acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= MUL_CNT_W'(MUL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[PW-2:0], 1'b0} + (b_q[MUL_W-1] ? PW'(a_q) : '0);
			b_q   <= {b_q[MUL_W-2:0], 1'b0};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule

// ===== hdl/agfm_serdiv.sv =====
// Restoring divider, one quotient bit per cycle, narrow divisor.
module agfm_serdiv import agfm_pkg::*; #(
	parameter int NW = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NW-1:0]    dividend,
	input  logic [WIN_W-1:0] divisor,
	output unit_stat_t       stat,
	output logic [NW-1:0]    quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0]    n_q;     // dividend bits out at the top, quotient bits in at the bottom
	logic [WIN_W-1:0] r_q;
	logic [WIN_W-1:0] d_q;
	logic [CW-1:0]    cnt_q;
	logic             done_q;
	logic [WIN_W:0]   trial;
	logic             ge;
	logic [WIN_W:0]   diff;

	assign trial = {r_q, n_q[NW-1]};
	assign ge    = (trial >= {1'b0, d_q});
	assign diff  = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so WIN_W bits hold it
			r_q <= ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
			n_q <= {n_q[NW-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = n_q;

endmodule

// ===== hdl/adaptive_gate_frequency_meter_unit.sv =====
// Top level of the adaptive gate frequency meter.
//
// Reciprocal gate-time frequency meter. Each input beat is one gate tick
// carrying the pulse counter's wrap count and residual value; the tick adds
// wrap_count*65536 + counter_value into a saturating SUM_BITS accumulator.
// A tick that does not close the window is simply accumulated. The tick
// that closes a window (tuning_period ticks in tuning mode, normal_period
// otherwise, a period of 0 meaning 256) starts the result computation:
// a bit-serial multiply by scale_q8 (run alongside a second one
// forming last frequency * tolerance_q16), then a restoring divide by the
// window length that produces one quotient bit per cycle over SUM_BITS+16
// bits, then saturation and the ST_CMP and ST_FIN compare states. That tick
// therefore holds s_tready low through the whole computation, the divide
// being the longest part, and longer if the previous result beat has not
// yet been taken. The result beat carries the frequency in Hz, unsigned Q.8
// saturated to 40 bits, and the mode chosen for the next window: tuning
// when |f - last| * 65536 > last * tolerance_q16, else normal. Reset starts
// in tuning mode. Registers are written through cfg_we/cfg_index/cfg_data
// and should only be changed while the block is idle.
module adaptive_gate_frequency_meter_unit import agfm_pkg::*; #(
	parameter int SUM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input gate ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] wrap_count, [23:8] counter_value
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [39:0] frequency_q8, [40] tuning_mode, [47:41] zero
	// register writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = SUM_BITS + MUL_W;   // scaled sum width
	localparam int RW = FREQ_W + MUL_W;     // change-test product width

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_CMP,
		ST_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  normal_period_q;
	logic [7:0]  tuning_period_q;
	logic [15:0] scale_q8_q;
	logic [15:0] tolerance_q16_q;

	// meter state
	logic [SUM_BITS-1:0] sum_q;
	logic [7:0]          tick_q;
	logic                fast_q;
	logic [FREQ_W-1:0]   last_q;
	logic [WIN_W-1:0]    window_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [FREQ_W-1:0]   diff_q;
	logic                m_tvalid_q;
	logic [47:0]         m_tdata_q;

	// input side
	logic                s_accept;
	logic [ADD_W-1:0]    add;
	logic [SUM_BITS:0]   sum_wide;
	logic [SUM_BITS-1:0] sum_sat;
	logic [7:0]          period;
	logic [WIN_W-1:0]    window;
	logic [WIN_W-1:0]    next_tick;
	logic                win_end;

	// arithmetic units
	unit_stat_t      mul_st, tol_st, div_st;
	logic [PW-1:0]   scaled;
	logic [RW-1:0]   rhs;
	logic [PW-1:0]   quot;
	logic [FREQ_W-1:0] freq_sat;
	logic            changed;
	logic            out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_period_q <= 8'd76;
			tuning_period_q <= 8'd25;
			scale_q8_q      <= 16'd15625;
			tolerance_q16_q <= 16'd164;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NORMAL_PERIOD: normal_period_q <= cfg_data[7:0];
				REG_TUNING_PERIOD: tuning_period_q <= cfg_data[7:0];
				REG_SCALE_Q8:      scale_q8_q      <= cfg_data;
				REG_TOLERANCE_Q16: tolerance_q16_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	assign add      = {s_tdata[7:0], s_tdata[23:8]};
	assign sum_wide = {1'b0, sum_q} + (SUM_BITS+1)'(add);
	assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

	assign period    = fast_q ? tuning_period_q : normal_period_q;
	assign window    = (period == 8'd0) ? WIN_W'(256) : WIN_W'(period);
	assign next_tick = WIN_W'(tick_q) + 1'b1;
	// a period lowered mid-window closes the window at once
	assign win_end   = (next_tick >= window);

	agfm_sermul #(.AW(SUM_BITS)) u_scale_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_accept && win_end),
		.a       (sum_sat),
		.b       (scale_q8_q),
		.stat    (mul_st),
		.product (scaled)
	);

	// last * tolerance for the change test, runs beside the scale multiply
	agfm_sermul #(.AW(FREQ_W)) u_tol_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (s_accept && win_end),
		.a       (last_q),
		.b       (tolerance_q16_q),
		.stat    (tol_st),
		.product (rhs)
	);

	agfm_serdiv #(.NW(PW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_st.done),
		.dividend (scaled),
		.divisor  (window_q),
		.stat     (div_st),
		.quotient (quot)
	);

	assign freq_sat = (quot > PW'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
	assign changed  = ({diff_q, {MUL_W{1'b0}}} > rhs);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			sum_q      <= '0;
			tick_q     <= '0;
			fast_q     <= 1'b1;
			last_q     <= '0;
			window_q   <= '0;
			freq_q     <= '0;
			diff_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// in ST_FIN the result register is reloaded below instead
			if (m_tvalid_q && m_tready && state_q != ST_FIN)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						if (win_end) begin
							// sum goes to the multiplier, accumulator restarts
							sum_q    <= '0;
							tick_q   <= '0;
							window_q <= window;
							state_q  <= ST_MUL;
						end else begin
							sum_q  <= sum_sat;
							tick_q <= next_tick[7:0];
						end
					end
				end
				ST_MUL: begin
					if (mul_st.done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						freq_q  <= freq_sat;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					diff_q  <= (freq_q >= last_q) ? freq_q - last_q : last_q - freq_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						fast_q     <= changed;
						last_q     <= freq_q;
						m_tdata_q  <= {7'd0, changed, freq_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "adaptive_gate_frequency_meter_unit_assert.svh"

	// no tick is taken while a serial unit is still working
	`AGFM_ASSERT_NOW(a_idle_units, s_tready, !mul_st.busy && !tol_st.busy && !div_st.busy)
	// both multipliers are started together and finish together
	`AGFM_ASSERT_NOW(a_mul_lockstep, mul_st.done || tol_st.done, mul_st.done && tol_st.done)
	// the divide follows the scale multiply directly
	`AGFM_ASSERT_NXT(a_div_follows, mul_st.done, div_st.busy && state_q == ST_DIV)
	// a closing tick clears the accumulator and tick count
	`AGFM_ASSERT_NXT(a_sum_cleared, s_accept && win_end, sum_q == '0 && tick_q == '0)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the adaptive gate frequency meter unit.
module tb import agfm_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SUM_BITS     = 32;
	localparam int DRAIN_CYCLES = SUM_BITS + 64;  // covers a closing tick's computation
	localparam int QUIET_LIMIT  = 4000;           // cycles without a beat on either side
	localparam int GAP_PCT      = 31;

	// one gate tick, laid out exactly as s_tdata
	typedef struct packed {
		logic [15:0] resid;
		logic [7:0]  wraps;
	} gate_tick_t;

	// one window reading, laid out as m_tdata[40:0]
	typedef struct packed {
		logic              mode;
		logic [FREQ_W-1:0] freq;
	} reading_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_NORMAL_PERIOD;
	logic [15:0] cfg_data  = '0;

	adaptive_gate_frequency_meter_unit #(.SUM_BITS(SUM_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// ticks waiting to be sent; entry 0 is the one on the bus while s_tvalid is high
	gate_tick_t tick_queue[$];
	// readings predicted but not yet seen on the result side
	reading_t   expected_readings[$];

	bit gaps_on = 1'b1;  // random idling on both sides
	int errors  = 0;
	int quiet   = 0;

	// meter state as the predictor sees it
	logic [7:0]        normal_len   = 8'd76;
	logic [7:0]        tuning_len   = 8'd25;
	logic [15:0]       scale        = 16'd15625;
	logic [15:0]       tolerance    = 16'd164;
	logic [63:0]       pulse_acc    = '0;
	logic [7:0]        tick_cnt     = '0;
	logic              fast_sel     = 1'b1;   // reset starts in tuning mode
	logic [FREQ_W-1:0] prev_freq    = '0;

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	// Fold one accepted tick into the predicted state; queue a reading if
	// the tick closes the window.
	task automatic account_tick(input gate_tick_t t);
		logic [63:0] add;
		logic [63:0] acc_max;
		logic [63:0] win;
		logic [63:0] nxt;
		logic [63:0] freq;
		logic [63:0] diff;
		logic [63:0] lhs;
		logic [63:0] rhs;
		add     = {40'd0, t.wraps, t.resid};
		acc_max = (64'd1 << SUM_BITS) - 64'd1;
		win     = {56'd0, fast_sel ? tuning_len : normal_len};
		if (win == 64'd0)
			win = 64'd256;          // period of 0 means 256 ticks
		nxt = {56'd0, tick_cnt} + 64'd1;
		if (pulse_acc > acc_max - add)
			pulse_acc = acc_max;    // accumulator saturates
		else
			pulse_acc = pulse_acc + add;
		if (nxt < win) begin
			tick_cnt = nxt[7:0];
		end else begin
			// also taken when the period was lowered below the count mid-window
			tick_cnt  = '0;
			freq      = (pulse_acc * {48'd0, scale}) / win;
			if (freq > {24'd0, FREQ_MAX})
				freq = {24'd0, FREQ_MAX};
			pulse_acc = '0;
			diff      = (freq >= {24'd0, prev_freq}) ? freq - {24'd0, prev_freq}
				: {24'd0, prev_freq} - freq;
			lhs       = diff << 16;
			rhs       = {24'd0, prev_freq} * {48'd0, tolerance};
			fast_sel  = (lhs > rhs);
			prev_freq = freq[FREQ_W-1:0];
			expected_readings.push_back({fast_sel, prev_freq});
		end
	endtask

	// Driver: presents ticks from tick_queue, predicts on each accepted beat.
	// Data only moves when the bus is free or the current beat was taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				account_tick(tick_queue[0]);
				void'(tick_queue.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 &&
						!(gaps_on && $urandom_range(0, 99) < GAP_PCT)) begin
					s_tvalid <= 1'b1;
					s_tdata  <= tick_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result beat against the oldest prediction.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_readings.size() == 0) begin
					note_error($sformatf("unexpected reading: freq=%0d mode=%0b",
						m_tdata[FREQ_W-1:0], m_tdata[FREQ_W]));
				end else begin
					want = expected_readings.pop_front();
					if (m_tdata[FREQ_W-1:0] !== want.freq)
						note_error($sformatf("frequency_q8 mismatch: expected %0d got %0d",
							want.freq, m_tdata[FREQ_W-1:0]));
					if (m_tdata[FREQ_W] !== want.mode)
						note_error($sformatf("tuning_mode mismatch: expected %0b got %0b",
							want.mode, m_tdata[FREQ_W]));
				end
			end
			m_tready <= !(gaps_on && $urandom_range(0, 99) < GAP_PCT);
		end
	end

	// Watchdog: a long stretch with no beat on either side means a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic push_tick(input logic [7:0] wraps, input logic [15:0] resid);
		tick_queue.push_back({resid, wraps});
	endtask

	// Hold the sender until every tick is taken and every reading is back,
	// then let a closing tick's computation run out.
	task automatic settle();
		while (tick_queue.size() != 0 || expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_NORMAL_PERIOD: normal_len = val[7:0];
			REG_TUNING_PERIOD: tuning_len = val[7:0];
			REG_SCALE_Q8:      scale      = val;
			REG_TOLERANCE_Q16: tolerance  = val;
			default: ;
		endcase
	endtask

	// Writes all four registers back to back while the meter is idle.
	task automatic apply_settings(input logic [7:0] np, input logic [7:0] tp,
			input logic [15:0] sc, input logic [15:0] tol);
		settle();
		write_reg(REG_NORMAL_PERIOD, {8'd0, np});
		write_reg(REG_TUNING_PERIOD, {8'd0, tp});
		write_reg(REG_SCALE_Q8, sc);
		write_reg(REG_TOLERANCE_Q16, tol);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'd255;
		if (r < 20)
			return 8'd1;
		return 8'($urandom_range(1, 8));
	endfunction

	function automatic logic [15:0] pick_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'hFFFF;
		if (r < 15)
			return 16'd1;
		if (r < 18)
			return 16'd0;
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic logic [15:0] pick_tolerance();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return 16'd0;
		if (r < 25)
			return 16'hFFFF;
		return 16'($urandom_range(0, 4000));
	endfunction

	// Mostly a steady input with small jitter so that windows settle into
	// normal mode, with frequency steps and raw noise mixed in.
	task automatic random_ticks(input int count);
		logic [7:0]  base_w;
		logic [15:0] base_r;
		int          r;
		base_w = 8'($urandom_range(0, 255));
		base_r = 16'($urandom_range(0, 65535));
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				push_tick(base_w, base_r + 16'($urandom_range(0, 31)) - 16'd16);
			end else if (r < 85) begin
				base_w = 8'($urandom_range(0, 255));
				base_r = 16'($urandom_range(0, 65535));
				push_tick(base_w, base_r);
			end else begin
				push_tick(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset leaves tuning mode on: a one-tick tuning window closes first,
		// and its zero reading against a zero history picks normal mode.
		apply_settings(8'd2, 8'd1, 16'd15625, 16'd164);
		push_tick(8'd0, 16'd0);
		push_tick(8'd0, 16'd5);
		push_tick(8'd0, 16'd7);

		// One-tick windows, widest scale, exact change test with zero tolerance:
		// a repeated value must drop back to normal mode.
		apply_settings(8'd1, 8'd1, 16'hFFFF, 16'd0);
		push_tick(8'hFF, 16'hFFFF);
		push_tick(8'd0, 16'd1);
		push_tick(8'd0, 16'd1);
		push_tick(8'hAA, 16'h5555);
		push_tick(8'h55, 16'hAAAA);

		// Long windows; two full-scale ticks stay in the accumulator.
		apply_settings(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
		push_tick(8'hFF, 16'hFFFF);
		push_tick(8'hFF, 16'hFFFF);

		// Period cut below the count mid-window: the next tick closes it with
		// three ticks over a divisor of one, which saturates the frequency.
		apply_settings(8'd1, 8'd1, 16'hFFFF, 16'hFFFF);
		push_tick(8'hFF, 16'hFFFF);

		// Scale of zero reads zero whatever the count.
		apply_settings(8'd1, 8'd1, 16'd0, 16'd164);
		push_tick(8'hFF, 16'hFFFF);
		push_tick(8'h12, 16'h3456);

		// Random settings; each phase boundary also drains all results.
		for (int ph = 0; ph < 10; ph++) begin
			apply_settings(pick_period(), pick_period(), pick_scale(), pick_tolerance());
			gaps_on = (ph != 3);   // one phase runs both sides flat out
			random_ticks(60);
		end
		gaps_on = 1'b1;

		// Period of zero: 256-tick windows at a scale of one.
		apply_settings(8'd0, 8'd0, 16'd1, 16'($urandom_range(0, 65535)));
		random_ticks(260);

		settle();
		while (expected_readings.size() != 0) begin
			note_error("reading never arrived");
			void'(expected_readings.pop_front());
		end
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/agfm_pkg.sv
hdl/agfm_sermul.sv
hdl/agfm_serdiv.sv
hdl/adaptive_gate_frequency_meter_unit.sv
verif/tb.sv
